@@ src/bmp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the binomial-modulo-prime pipeline.
package bmp_pkg;

    typedef logic [29:0] residue_t;

    localparam logic [29:0] PRIME      = 30'd1000000007;
    localparam logic [29:0] FERMAT_EXP = 30'd1000000005;
    localparam logic [31:0] PRIME_X2   = 32'd2000000014;
    // Barrett constant floor(2^60 / p), which fits in 31 bits.
    localparam logic [63:0] MU_FULL    = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

endpackage

@@ src/bmp_rom.sv @@
`timescale 1ns / 1ps
// Factorial and inverse-factorial tables with registered reads; first pipeline stage.
module bmp_rom
    import bmp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  logic [9:0] n_value,
    input  logic [9:0] k_value,
    output logic       out_valid,
    output residue_t   fact_n,
    output residue_t   inv_k,
    output residue_t   inv_nk,
    output logic       invalid
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef logic [29:0] tbl_t [TABLE_DEPTH];

    // Shift-and-add product modulo the prime; both operands are already reduced.
    function automatic logic [29:0] mm(input logic [29:0] x, input logic [29:0] y);
        logic [31:0] acc;
        acc = 32'd0;
        for (int b = 29; b >= 0; b--)
        begin
            acc = acc << 1;
            if (acc >= 32'(PRIME))
            begin
                acc = acc - 32'(PRIME);
            end
            if (y[b])
            begin
                acc = acc + 32'(x);
                if (acc >= 32'(PRIME))
                begin
                    acc = acc - 32'(PRIME);
                end
            end
        end
        return acc[29:0];
    endfunction

    function automatic tbl_t fact_table();
        tbl_t t;
        t[0] = 30'd1;
        for (int i = 1; i < TABLE_DEPTH; i++)
        begin
            t[i] = mm(t[i - 1], 30'(i));
        end
        return t;
    endfunction

    // Inverse of the last factorial by Fermat, then walked down by multiplying by i.
    function automatic tbl_t inv_table();
        tbl_t        f;
        tbl_t        t;
        logic [29:0] acc;
        logic [29:0] sq;
        f   = fact_table();
        acc = 30'd1;
        sq  = f[TABLE_DEPTH - 1];
        for (int b = 0; b < 30; b++)
        begin
            if (FERMAT_EXP[b])
            begin
                acc = mm(acc, sq);
            end
            sq = mm(sq, sq);
        end
        t[TABLE_DEPTH - 1] = acc;
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            t[i - 1] = mm(t[i], 30'(i));
        end
        return t;
    endfunction

    localparam tbl_t FACT_ROM = fact_table();
    localparam tbl_t INV_ROM  = inv_table();

    logic          bad;
    logic [9:0]    diff;
    logic [AW-1:0] addr_n;
    logic [AW-1:0] addr_k;
    logic [AW-1:0] addr_nk;
    logic          valid_reg;

    // A bad query reads entry zero so that no read falls outside the tables.
    always_comb
    begin
        bad     = (k_value > n_value) || (32'(n_value) >= TABLE_DEPTH);
        diff    = n_value - k_value;
        addr_n  = bad ? '0 : AW'(n_value);
        addr_k  = bad ? '0 : AW'(k_value);
        addr_nk = bad ? '0 : AW'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // A bad query carries a zero numerator so that the product comes out as zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fact_n  <= bad ? 30'd0 : FACT_ROM[addr_n];
            inv_k   <= INV_ROM[addr_k];
            inv_nk  <= INV_ROM[addr_nk];
            invalid <= bad;
        end
    end

    assign out_valid = valid_reg;

endmodule

@@ src/bmp_mulmod.sv @@
`timescale 1ns / 1ps
// Four-stage modular multiplier with Barrett reduction and a sideband that travels alongside.
module bmp_mulmod
    import bmp_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  residue_t        a,
    input  residue_t        b,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output residue_t        result,
    output logic [SB_W-1:0] sb_out
);

    logic [3:0]      valid_reg;
    logic [59:0]     prod_reg;
    logic [61:0]     q2_reg;
    logic [31:0]     xlo_reg;
    logic [31:0]     r_reg;
    residue_t        res_reg;
    logic [SB_W-1:0] sb0_reg;
    logic [SB_W-1:0] sb1_reg;
    logic [SB_W-1:0] sb2_reg;
    logic [SB_W-1:0] sb3_reg;

    logic [30:0]     q3;
    logic [60:0]     qp;
    logic [31:0]     r_next;
    residue_t        res_next;

    always_comb
    begin
        q3     = q2_reg[61:31];
        qp     = 61'(q3) * 61'(PRIME);
        r_next = xlo_reg - qp[31:0];
        // The Barrett estimate leaves the remainder below three times the prime.
        if (r_reg >= PRIME_X2)
        begin
            res_next = 30'(r_reg - PRIME_X2);
        end
        else if (r_reg >= 32'(PRIME))
        begin
            res_next = 30'(r_reg - 32'(PRIME));
        end
        else
        begin
            res_next = r_reg[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 4'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 60'(a) * 60'(b);
            sb0_reg  <= sb_in;
            q2_reg   <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
            xlo_reg  <= prod_reg[31:0];
            sb1_reg  <= sb0_reg;
            r_reg    <= r_next;
            sb2_reg  <= sb1_reg;
            res_reg  <= res_next;
            sb3_reg  <= sb2_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign result    = res_reg;
    assign sb_out    = sb3_reg;

endmodule

@@ src/binomial_mod_prime.sv @@
`timescale 1ns / 1ps
// Top level: n choose k modulo 1000000007 from factorial tables and two modular multipliers.
//
// Channel | Direction | tdata                              | tuser
// s_axis  | in        | [9:0] n_value, [19:10] k_value     | -
// m_axis  | out       | [29:0] binomial                    | [0] invalid
//
// One query enters per cycle while the output is not stalled and passes nine register stages:
// one table read stage and two four-stage Barrett multipliers.
// Reset clears every valid bit; the tables are constants and need no fill.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module binomial_mod_prime
    import bmp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // n_value, k_value, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // binomial, zero fill
    output logic        m_tuser    // invalid
);

    logic     en;
    logic     rom_valid;
    residue_t fact_n;
    residue_t inv_k;
    residue_t inv_nk;
    logic     rom_bad;
    logic     den_valid;
    residue_t den_inv;
    logic [30:0] den_sb;
    logic     out_valid;
    residue_t out_res;
    logic     out_bad;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    bmp_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .n_value   (s_tdata[9:0]),
        .k_value   (s_tdata[19:10]),
        .out_valid (rom_valid),
        .fact_n    (fact_n),
        .inv_k     (inv_k),
        .inv_nk    (inv_nk),
        .invalid   (rom_bad)
    );

    bmp_mulmod #(
        .SB_W (31)
    ) u_mul_den (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rom_valid),
        .a         (inv_k),
        .b         (inv_nk),
        .sb_in     ({rom_bad, fact_n}),
        .out_valid (den_valid),
        .result    (den_inv),
        .sb_out    (den_sb)
    );

    bmp_mulmod #(
        .SB_W (1)
    ) u_mul_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (den_valid),
        .a         (den_sb[29:0]),
        .b         (den_inv),
        .sb_in     (den_sb[30]),
        .out_valid (out_valid),
        .result    (out_res),
        .sb_out    (out_bad)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {2'b00, out_res};
    assign m_tuser  = out_bad;

endmodule

@@ src/bmp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the binomial pipeline and its bind to the top level.
module bmp_checker
    import bmp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("invalid query gave a nonzero result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata < 32'(PRIME))
        else $error("result not reduced below the prime");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
